[hdl/dicom_element_header_parser_core_macros.svh]
// Assertion macros shared by the parser RTL.
`ifndef DICOM_ELEMENT_HEADER_PARSER_CORE_MACROS_SVH
`define DICOM_ELEMENT_HEADER_PARSER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define DEHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition must never be seen outside reset.
`define DEHP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define DEHP_ASSERT(lbl, prop, msg)
`define DEHP_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[hdl/dehp_pkg.sv]
// Types, constants and byte-order helpers for the DICOM element header parser.
package dehp_pkg;

  localparam int MAX_NESTING_DEF = 8;
  localparam int RES_QUEUE_DEPTH = 3;

  localparam logic [15:0] GRP_DELIM     = 16'hfffe;
  localparam logic [15:0] ELM_ITEM      = 16'he000;
  localparam logic [15:0] ELM_ITEM_END  = 16'he00d;
  localparam logic [15:0] ELM_SEQ_END   = 16'he0dd;
  localparam logic [31:0] LEN_UNDEFINED = 32'hffff_ffff;
  localparam logic [31:0] POS_MAX       = 32'hffff_ffff;

  // Register indexes on the config port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_VR_PRESENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LE_ORDER   = 1'b1;

  // VRs that take two reserved bytes and a 32-bit length
  localparam int NUM_LONG_VR = 13;
  localparam logic [15:0] LONG_VR [NUM_LONG_VR] = '{
    "OB", "OD", "OF", "OL", "OV", "OW", "SQ", "SV", "UC", "UN", "UR", "UT", "UV"
  };

  typedef enum logic [2:0] {
    PH_TAG      = 3'd0,
    PH_VR       = 3'd1,
    PH_RSVD     = 3'd2,
    PH_LONGLEN  = 3'd3,
    PH_SHORTLEN = 3'd4,
    PH_IMPLEN   = 3'd5,
    PH_VALUE    = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    KIND_HEADER     = 3'd0,
    KIND_END_OK     = 3'd1,
    KIND_END_TRUNC  = 3'd2,
    KIND_END_UNTERM = 3'd3,
    KIND_END_OVFL   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] grp;
    logic [15:0] elm;
    logic [15:0] vr;
    logic [31:0] len;
    logic        undef;
    logic [31:0] off;
    logic [3:0]  depth;
    logic        last;
  } res_t;

  function automatic logic [15:0] order16(logic [15:0] v, logic le);
    return le ? {v[7:0], v[15:8]} : v;
  endfunction

  function automatic logic [31:0] order32(logic [31:0] v, logic le);
    return le ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
  endfunction

  function automatic logic is_long_vr(logic [15:0] vr);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_LONG_VR; i++) begin
      hit = hit | (vr == LONG_VR[i]);
    end
    return hit;
  endfunction

endpackage

[hdl/dehp_res_queue.sv]
// Result queue: takes up to two results a cycle while it has room for two, presents the head from a register.
`include "dicom_element_header_parser_core_macros.svh"

module dehp_res_queue
  import dehp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_a_i,
  input  res_t res_a_i,
  input  logic push_b_i,
  input  res_t res_b_i,
  output logic room_o,
  output logic head_valid_o,
  output res_t head_o,
  input  logic pop_i
);

  localparam int CntW = $clog2(RES_QUEUE_DEPTH + 1);

  res_t            slot_q [RES_QUEUE_DEPTH];
  res_t            slot_d [RES_QUEUE_DEPTH];
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] base;
  logic            pop;

  assign pop          = pop_i && (count_q != '0);
  assign room_o       = count_q <= CntW'(RES_QUEUE_DEPTH - 2);
  assign head_valid_o = count_q != '0;
  assign head_o       = slot_q[0];

  always_comb begin
    base = pop ? count_q - CntW'(1) : count_q;
    for (int i = 0; i < RES_QUEUE_DEPTH; i++) begin
      if (pop && (i < RES_QUEUE_DEPTH - 1)) begin
        slot_d[i] = slot_q[i+1];
      end else begin
        slot_d[i] = slot_q[i];
      end
      if (push_a_i && (base == CntW'(i))) begin
        slot_d[i] = res_a_i;
      end
      if (push_b_i && (base + CntW'(1) == CntW'(i))) begin
        slot_d[i] = res_b_i;
      end
    end
    count_d = base + CntW'(push_a_i) + CntW'(push_b_i);
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  `DEHP_ASSERT(a_count_bound, count_q <= CntW'(RES_QUEUE_DEPTH), "queue count out of range")
  `DEHP_ASSERT(a_b_after_a, push_b_i |-> push_a_i, "second result without first")
  `DEHP_ASSERT(a_push_room, push_a_i |-> room_o, "result pushed with no room")

endmodule

[hdl/dicom_element_header_parser_core.sv]
// Results of a byte go into a registered result queue and reach m_axis from its head.
// Throughput: one byte per cycle while the result queue has room; a byte giving both
// a header and an end result puts both into the queue and holds the next byte off.
// s_axis_tready depends only on queue occupancy, set by the output drain rate.
// Reset (rst_ni, async, active low): parser idle awaiting a tag, queue empty,
// explicit-VR flag clear, little-endian order set; delimiter stack contents undefined.
`include "dicom_element_header_parser_core_macros.svh"

module dicom_element_header_parser_core
  import dehp_pkg::*;
#(
  parameter int MaxNesting = MAX_NESTING_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic                 cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // [7:0] data_byte
  input  logic                 s_axis_tlast,  // last_byte
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [15:0] group_number, [31:16] element_number, [47:32] vr_code,
  // [79:48] value_length, [80] undef_len, [112:81] val_offset,
  // [116:113] nesting_depth, [119:117] zero
  output logic [119:0]         m_axis_tdata,
  output logic [2:0]           m_axis_tuser,  // [2:0] result_kind
  output logic                 m_axis_tlast   // last_result (set on end results and on headers of a non-last byte)
);

  localparam int DepthW = $clog2(MaxNesting + 1);

  logic vr_present_q, le_order_q;

  phase_e            phase_q, phase_d;
  logic [3:0]        hbc_q, hbc_d;
  logic [31:0]       tag_q, tag_d;
  logic [15:0]       vr_q, vr_d;
  logic [31:0]       len_q, len_d;
  logic [31:0]       vbl_q, vbl_d;
  logic [31:0]       pos_q, pos_d;
  logic [MaxNesting-1:0] stack_q, stack_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic              ovf_q, ovf_d;

  logic        in_acc, done, wide, popped, mid;
  logic [15:0] grp, elm, want;
  logic [31:0] len_val;
  logic        undef;
  res_t        hdr_res, end_res;
  logic        push_a, push_b;
  res_t        res_a;
  logic        room;
  res_t        head;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = room;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_present_q <= 1'b0;
      le_order_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VR_PRESENT: vr_present_q <= cfg_data_i;
        REG_LE_ORDER:   le_order_q   <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    phase_d = phase_q;
    hbc_d   = hbc_q;
    tag_d   = tag_q;
    vr_d    = vr_q;
    len_d   = len_q;
    vbl_d   = vbl_q;
    pos_d   = pos_q;
    stack_d = stack_q;
    depth_d = depth_q;
    ovf_d   = ovf_q;
    done    = 1'b0;
    wide    = 1'b0;
    popped  = 1'b0;
    mid     = 1'b0;
    grp     = order16(tag_q[31:16], le_order_q);
    elm     = order16(tag_q[15:0], le_order_q);
    want    = stack_q[0] ? ELM_ITEM_END : ELM_SEQ_END;
    len_val = '0;
    undef   = 1'b0;
    hdr_res = '0;
    end_res = '0;

    if (in_acc) begin
      pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + 32'd1;

      if (phase_q == PH_VALUE) begin
        vbl_d = vbl_q - 32'd1;
        if (vbl_d == '0) begin
          phase_d = PH_TAG;
        end
      end else begin
        hbc_d = hbc_q + 4'd1;
        case (phase_q)
          PH_TAG: begin
            tag_d = {tag_q[23:0], s_axis_tdata};
            if (hbc_d >= 4'd4) begin
              // delimiters are always implicit
              if ((order16(tag_d[31:16], le_order_q) == GRP_DELIM) || !vr_present_q) begin
                phase_d = PH_IMPLEN;
              end else begin
                phase_d = PH_VR;
              end
            end
          end
          PH_VR: begin
            vr_d = {vr_q[7:0], s_axis_tdata};
            if (hbc_d >= 4'd6) begin
              phase_d = is_long_vr(vr_d) ? PH_RSVD : PH_SHORTLEN;
            end
          end
          PH_RSVD: begin
            if (hbc_d >= 4'd8) begin
              phase_d = PH_LONGLEN;
            end
          end
          PH_LONGLEN: begin
            len_d = {len_q[23:0], s_axis_tdata};
            if (hbc_d >= 4'd12) begin
              done = 1'b1;
              wide = 1'b1;
            end
          end
          PH_SHORTLEN: begin
            len_d = {16'h0, len_q[7:0], s_axis_tdata};
            if (hbc_d >= 4'd8) begin
              done = 1'b1;
            end
          end
          default: begin
            len_d = {len_q[23:0], s_axis_tdata};
            if (hbc_d >= 4'd8) begin
              done = 1'b1;
              wide = 1'b1;
            end
          end
        endcase
      end

      if (done) begin
        len_val = wide ? order32(len_d, le_order_q)
                       : {16'h0, order16(len_d[15:0], le_order_q)};
        undef   = wide && (len_val == LEN_UNDEFINED);
        if ((depth_q != '0) && (grp == GRP_DELIM) && (elm == want)) begin
          depth_d = depth_q - DepthW'(1);
          stack_d = stack_q >> 1;
          popped  = 1'b1;
        end
        if (!popped && undef) begin
          if (depth_q < DepthW'(MaxNesting)) begin
            stack_d = (stack_q << 1)
                    | MaxNesting'((grp == GRP_DELIM) && (elm == ELM_ITEM));
            depth_d = depth_q + DepthW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        hdr_res.kind  = KIND_HEADER;
        hdr_res.grp   = grp;
        hdr_res.elm   = elm;
        hdr_res.vr    = (phase_q == PH_IMPLEN) ? 16'h0 : vr_q;
        hdr_res.len   = len_val;
        hdr_res.undef = undef;
        hdr_res.off   = pos_d;
        hdr_res.depth = 4'(depth_d);
        hdr_res.last  = !s_axis_tlast;
        phase_d = (undef || (len_val == '0)) ? PH_TAG : PH_VALUE;
        vbl_d   = len_val;
        hbc_d   = '0;
        tag_d   = '0;
        vr_d    = '0;
        len_d   = '0;
      end

      if (s_axis_tlast) begin
        mid = !((phase_d == PH_TAG) && (hbc_d == '0));
        if (ovf_d) begin
          end_res.kind = KIND_END_OVFL;
        end else if (mid) begin
          end_res.kind = KIND_END_TRUNC;
        end else if (depth_d != '0) begin
          end_res.kind = KIND_END_UNTERM;
        end else begin
          end_res.kind = KIND_END_OK;
        end
        end_res.off   = pos_d;
        end_res.depth = 4'(depth_d);
        end_res.last  = 1'b1;
        // start afresh for the next dataset
        phase_d = PH_TAG;
        hbc_d   = '0;
        tag_d   = '0;
        vr_d    = '0;
        len_d   = '0;
        vbl_d   = '0;
        pos_d   = '0;
        depth_d = '0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      hbc_q   <= '0;
      tag_q   <= '0;
      vr_q    <= '0;
      len_q   <= '0;
      vbl_q   <= '0;
      pos_q   <= '0;
      depth_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hbc_q   <= hbc_d;
      tag_q   <= tag_d;
      vr_q    <= vr_d;
      len_q   <= len_d;
      vbl_q   <= vbl_d;
      pos_q   <= pos_d;
      depth_q <= depth_d;
      ovf_q   <= ovf_d;
    end
  end

  // stack contents are only read below the depth, so no reset
  always_ff @(posedge clk_i) begin
    stack_q <= stack_d;
  end

  assign push_a = in_acc && (done || s_axis_tlast);
  assign push_b = in_acc && done && s_axis_tlast;
  assign res_a  = done ? hdr_res : end_res;

  dehp_res_queue u_res_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_a_i     (push_a),
    .res_a_i      (res_a),
    .push_b_i     (push_b),
    .res_b_i      (end_res),
    .room_o       (room),
    .head_valid_o (m_axis_tvalid),
    .head_o       (head),
    .pop_i        (m_axis_tready)
  );

  assign m_axis_tdata = {3'b000, head.depth, head.off, head.undef, head.len,
                         head.vr, head.elm, head.grp};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  `DEHP_ASSERT(a_depth_bound, depth_q <= DepthW'(MaxNesting), "nesting depth beyond stack size")
  `DEHP_ASSERT(a_value_phase, (phase_q == PH_VALUE) |-> ((vbl_q != '0) && (hbc_q == '0)),
               "value phase with nothing left to skip")
  `DEHP_ASSERT(a_end_clears, (in_acc && s_axis_tlast) |=>
               ((phase_q == PH_TAG) && (depth_q == '0) && (pos_q == '0) && !ovf_q),
               "parser not cleared after last byte")

endmodule
